// ===== sv/motor_status_frame_parser_defines.svh =====
// Assertion helpers shared by the parser's RTL.
`ifndef MOTOR_STATUS_FRAME_PARSER_DEFINES_SVH
`define MOTOR_STATUS_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, masked while reset is low
`define MSFP_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low
`define MSFP_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/msfp_pkg.sv =====
package msfp_pkg;

    // Frame header and block markers
    localparam logic [7:0] HDR0      = 8'hA6;
    localparam logic [7:0] HDR1      = 8'h6A;
    localparam logic [7:0] BUS_MASK  = 8'hF0;
    localparam logic [7:0] ID_MASK   = 8'h0F;
    localparam logic [7:0] BUS1_CODE = 8'h10;
    localparam logic [7:0] BUS2_CODE = 8'h20;
    localparam logic [7:0] IMU_MARK  = 8'hAA;
    localparam logic [7:0] FOOT_MARK = 8'hBB;

    // First record byte follows header (2 bytes) and count byte
    localparam int REC_START  = 3;
    // Two foot sensors of three bytes each
    localparam int FOOT_BYTES = 6;

    // Queue between front and back; depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Section codes
    localparam logic [1:0] SEC_BUS1 = 2'd0;
    localparam logic [1:0] SEC_BUS2 = 2'd1;
    localparam logic [1:0] SEC_IMU  = 2'd2;
    localparam logic [1:0] SEC_FOOT = 2'd3;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HDR  = 2'd1;
    localparam logic [1:0] ST_COUNT_MM = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_BUS1_COUNT = 2'd0;
    localparam logic [1:0] REG_BUS2_COUNT = 2'd1;
    localparam logic [1:0] REG_IMU_EN     = 2'd2;
    localparam logic [1:0] REG_FOOT_EN    = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic       write_valid;
        logic [1:0] section;
        logic [3:0] entry;
        logic [5:0] byte_offset;
        logic [7:0] byte_value;
        logic       frame_end;
        logic [1:0] frame_status;
    } t_out_item;

    typedef struct packed {
        logic [3:0] bus1_motor_count;
        logic [3:0] bus2_motor_count;
        logic       imu_enable;
        logic       foot_enable;
    } t_cfg;

    // Queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== sv/msfp_front.sv =====
module msfp_front #(
    parameter int FRAME_BYTES  = 256,
    parameter int RECORD_BYTES = 16,
    parameter int IMU_BYTES    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  msfp_pkg::t_in_item i_item,
    output logic               o_stall,
    input  msfp_pkg::t_cfg     i_cfg,
    input  msfp_pkg::t_q_status i_q_stat,
    output logic               o_push,
    output msfp_pkg::t_out_item o_push_item
);
    import msfp_pkg::*;

    // Position counter holds FRAME_BYTES once the frame is over
    localparam int P_W = $clog2(FRAME_BYTES + 1);
    // Wide enough for the record end plus inertial and foot blocks
    localparam int E_W = $clog2(REC_START + 255 * RECORD_BYTES + IMU_BYTES + FOOT_BYTES + 2);
    localparam int K_W = (RECORD_BYTES > 2) ? $clog2(RECORD_BYTES) : 1;

    logic [P_W-1:0] r_pos, n_pos, pos_eff;
    logic [E_W-1:0] r_rec_end, n_rec_end;
    logic [E_W-1:0] r_fmp, n_fmp, fmp_use;
    logic [K_W-1:0] r_k, n_k;
    logic [1:0]     r_err, n_err;
    logic [1:0]     r_sec, n_sec;
    logic [3:0]     r_entry, n_entry;
    logic           r_skip, n_skip;
    logic           r_imu, n_imu;
    logic           r_foot, n_foot;

    logic           accept, active;
    logic [E_W-1:0] pos_e, imu_last, foot_last, imu_off, foot_off;
    logic [7:0]     b;
    logic [7:0]     bus, id;
    t_out_item      res;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign b       = i_item.rx_byte;
    assign pos_eff = i_item.frame_start ? '0 : r_pos;
    assign active  = pos_eff < P_W'(FRAME_BYTES);
    assign pos_e   = E_W'(pos_eff);
    assign bus     = b & BUS_MASK;
    assign id      = b & ID_MASK;

    assign imu_last  = r_rec_end + E_W'(IMU_BYTES);
    assign foot_last = fmp_use + E_W'(FOOT_BYTES);
    assign imu_off   = pos_e - r_rec_end - E_W'(1);
    assign foot_off  = pos_e - fmp_use - E_W'(1);

    // Byte classification and next frame state
    always_comb begin
        n_pos     = pos_eff + P_W'(1);
        n_rec_end = r_rec_end;
        n_fmp     = r_fmp;
        n_k       = r_k;
        n_err     = r_err;
        n_sec     = r_sec;
        n_entry   = r_entry;
        n_skip    = r_skip;
        n_imu     = r_imu;
        n_foot    = r_foot;
        fmp_use   = r_fmp;
        res       = '0;

        if (pos_eff == P_W'(0)) begin
            // fresh frame: clear all per-frame state
            n_err     = (b != HDR0) ? ST_BAD_HDR : ST_OK;
            n_rec_end = E_W'(REC_START);
            n_fmp     = '0;
            n_k       = '0;
            n_sec     = SEC_BUS1;
            n_entry   = '0;
            n_skip    = 1'b0;
            n_imu     = 1'b0;
            n_foot    = 1'b0;
        end else if (pos_eff == P_W'(1)) begin
            if (b != HDR1 && r_err == ST_OK) begin
                n_err = ST_BAD_HDR;
            end
        end else if (pos_eff == P_W'(2)) begin
            n_rec_end = E_W'(REC_START) + E_W'(b) * E_W'(RECORD_BYTES);
            n_k       = '0;
            if (r_err == ST_OK &&
                b != (8'(i_cfg.bus1_motor_count) + 8'(i_cfg.bus2_motor_count))) begin
                n_err = ST_COUNT_MM;
            end
        end else begin
            // byte index within the current record
            n_k = (r_k == K_W'(RECORD_BYTES - 1)) ? '0 : r_k + K_W'(1);
            if (r_err == ST_OK) begin
                if (pos_e < r_rec_end) begin
                    if (r_k == '0) begin
                        n_skip = 1'b1;
                        if (id != 8'd0 && (bus == BUS1_CODE || bus == BUS2_CODE)) begin
                            n_skip  = 1'b0;
                            n_sec   = (bus == BUS1_CODE) ? SEC_BUS1 : SEC_BUS2;
                            n_entry = id[3:0] - 4'd1;
                        end
                        res.byte_value = id;
                    end else begin
                        res.byte_value = b;
                    end
                    // a skipped record still shows its byte on a frame-end status
                    if (!n_skip) begin
                        res.write_valid = 1'b1;
                        res.section     = n_sec;
                        res.entry       = n_entry;
                        res.byte_offset = 6'(r_k);
                    end
                end else begin
                    // inertial marker or data
                    if (pos_e == r_rec_end) begin
                        if (i_cfg.imu_enable && b == IMU_MARK) begin
                            n_imu = 1'b1;
                            n_fmp = r_rec_end + E_W'(IMU_BYTES);
                        end else begin
                            n_fmp = r_rec_end;
                        end
                        fmp_use = n_fmp;
                    end else if (r_imu && pos_e <= imu_last) begin
                        res.write_valid = 1'b1;
                        res.section     = SEC_IMU;
                        res.byte_offset = imu_off[5:0];
                        res.byte_value  = b;
                    end
                    // foot marker or data
                    if (pos_e == fmp_use) begin
                        if (i_cfg.foot_enable && b == FOOT_MARK && !r_foot) begin
                            n_foot = 1'b1;
                        end
                    end else if (r_foot && pos_e > fmp_use && pos_e <= foot_last) begin
                        res.write_valid = 1'b1;
                        res.section     = SEC_FOOT;
                        res.entry       = '0;
                        res.byte_offset = foot_off[5:0];
                        res.byte_value  = b;
                    end
                end
            end
        end

        if (pos_eff == P_W'(FRAME_BYTES - 1)) begin
            res.frame_end    = 1'b1;
            res.frame_status = n_err;
        end
    end

    // Push a result only when the byte produced one
    always_comb begin
        o_push      = accept && active && (res.write_valid || res.frame_end);
        o_push_item = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_rec_end <= '0;
            r_fmp     <= '0;
            r_k       <= '0;
            r_err     <= ST_OK;
            r_sec     <= SEC_BUS1;
            r_entry   <= '0;
            r_skip    <= 1'b0;
            r_imu     <= 1'b0;
            r_foot    <= 1'b0;
        end else if (accept && active) begin
            r_pos     <= n_pos;
            r_rec_end <= n_rec_end;
            r_fmp     <= n_fmp;
            r_k       <= n_k;
            r_err     <= n_err;
            r_sec     <= n_sec;
            r_entry   <= n_entry;
            r_skip    <= n_skip;
            r_imu     <= n_imu;
            r_foot    <= n_foot;
        end
    end

endmodule

// ===== sv/msfp_queue.sv =====
module msfp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  msfp_pkg::t_out_item i_push_item,
    input  logic                i_pop,
    output msfp_pkg::t_out_item o_head,
    output msfp_pkg::t_q_status o_stat
);
    import msfp_pkg::*;

    t_out_item       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Occupancy update
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== sv/msfp_back.sv =====
module msfp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msfp_pkg::t_q_status i_q_stat,
    input  msfp_pkg::t_out_item i_head,
    output logic                o_pop,
    output logic                o_valid,
    output msfp_pkg::t_out_item o_item,
    input  logic                i_stall
);
    import msfp_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Refill the output register when it is empty or being taken
    assign o_pop   = !i_q_stat.empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

endmodule

// ===== sv/motor_status_frame_parser.sv =====
// Motor status frame parser: takes one received byte per transaction and emits at most one
// tagged status-store byte write per byte, plus the frame status on the last frame byte.
// It sustains one byte per clock while the queue is not full; the rate is set by the byte
// classifier in the front stage, which holds all frame position state. The classifier writes
// each result into a two-entry queue when its byte is accepted, and the output register
// loads from the queue; input and output can each stall without blocking the other until
// the queue fills. Registers bus1/bus2 motor count, IMU enable and foot enable sit at byte
// addresses 0, 4, 8 and 12 and should be written between frames.
`include "motor_status_frame_parser_defines.svh"

module motor_status_frame_parser #(
    parameter int FRAME_BYTES  = 256,
    parameter int RECORD_BYTES = 16,
    parameter int IMU_BYTES    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  msfp_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output msfp_pkg::t_out_item o_out_item,
    input  logic                i_out_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import msfp_pkg::*;

    t_cfg        r_cfg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        push, pop;
    t_out_item   push_item, head;
    t_q_status   q_stat;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BUS1_COUNT: r_cfg.bus1_motor_count <= pwdata[3:0];
                REG_BUS2_COUNT: r_cfg.bus2_motor_count <= pwdata[3:0];
                REG_IMU_EN:     r_cfg.imu_enable       <= pwdata[0];
                REG_FOOT_EN:    r_cfg.foot_enable      <= pwdata[0];
                default:        r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        case (cfg_idx)
            REG_BUS1_COUNT: prdata = 32'(r_cfg.bus1_motor_count);
            REG_BUS2_COUNT: prdata = 32'(r_cfg.bus2_motor_count);
            REG_IMU_EN:     prdata = 32'(r_cfg.imu_enable);
            REG_FOOT_EN:    prdata = 32'(r_cfg.foot_enable);
            default:        prdata = '0;
        endcase
    end

    msfp_front #(
        .FRAME_BYTES  (FRAME_BYTES),
        .RECORD_BYTES (RECORD_BYTES),
        .IMU_BYTES    (IMU_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_item      (i_in_item),
        .o_stall     (o_in_stall),
        .i_cfg       (r_cfg),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_item (push_item)
    );

    msfp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    msfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item),
        .i_stall  (i_out_stall)
    );

    // Every result is a store write or the frame end
    `MSFP_CHECK(a_result_kind, i_clk, i_rst_n, o_out_valid, o_out_item.write_valid || o_out_item.frame_end, "result without write or frame end")
    // Status only reported on the frame end
    `MSFP_CHECK(a_status_at_end, i_clk, i_rst_n, o_out_valid && !o_out_item.frame_end, o_out_item.frame_status == ST_OK, "status outside frame end")
    // Inertial and foot writes always use entry zero
    `MSFP_CHECK(a_block_entry, i_clk, i_rst_n, o_out_valid && o_out_item.write_valid && o_out_item.section[1], o_out_item.entry == 4'd0, "non-zero entry on block write")
    // Output drains when taken with nothing queued
    `MSFP_CHECK_NEXT(a_drain, i_clk, i_rst_n, o_out_valid && !i_out_stall && q_stat.empty, !o_out_valid, "stale result after drain")

endmodule
